// File: sv/tld_pkg.sv
// Shared types and constants for the trace loop detector.
package tld_pkg;

    localparam int ADDR_W  = 64;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 8;
    localparam int EVENT_W = 3;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [EVENT_W-1:0] event_t;

    // Event codes
    localparam event_t EV_NONE       = 3'd0;
    localparam event_t EV_LOCK       = 3'd1;
    localparam event_t EV_SQUELCH    = 3'd2;
    localparam event_t EV_EXIT_SQ    = 3'd3;
    localparam event_t EV_EXIT_QUIET = 3'd4;

    // Configuration register indexes
    localparam cfg_t REG_LOCK_THRESHOLD    = 8'd0;
    localparam cfg_t REG_SQUELCH_ITERATION = 8'd1;

    localparam cfg_t LOCK_THRESHOLD_RST    = 8'd5;
    localparam cfg_t SQUELCH_ITERATION_RST = 8'd4;

    localparam count_t COUNT_MAX = '1;

endpackage

// File: sv/trace_loop_detector.sv
// Trace loop detector top level: window cell chain, loop control and output register.
// Each accepted pc beat's result is registered and shows on the output in the next cycle.
// Throughput: one pc per cycle while the output is not stalled; the pc is compared against all window cells at
// once and the loop state updates in the same cycle.
// A stalled output holds its beat; a new pc is taken whenever the output slot frees.
// Reset clears control state and restores thresholds 5 and 4; window contents stay undefined.
module trace_loop_detector
#(
    parameter int WINDOW_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  tld_pkg::cfg_t          cfg_index,
    input  tld_pkg::cfg_t          cfg_data,
    // pc input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tld_pkg::addr_t         pc,
    // result channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output tld_pkg::event_t        event_res,
    output tld_pkg::count_t        iterations,
    output logic                   suppressing,
    output logic                   locked
);
    import tld_pkg::*;

    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

    // Configuration registers
    cfg_t lock_thr_reg;
    cfg_t squelch_iter_reg;

    // Loop state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              locked_reg, locked_next;
    logic              squelch_reg, squelch_next;
    cfg_t              hit_run_reg, hit_run_next;
    addr_t             head_reg, head_next;
    count_t            iter_reg, iter_next;

    // Output register
    logic   out_valid_reg;
    event_t event_reg, event_next;
    count_t iters_out_reg, iters_out_next;
    logic   suppressing_reg;
    logic   locked_out_reg;

    logic in_acc;
    logic shift_en;
    logic hit_any;
    logic full;
    cfg_t need;
    cfg_t run_inc;
    count_t iter_inc;

    addr_t                   chain [WINDOW_DEPTH+1];
    logic [WINDOW_DEPTH-1:0] hits;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_thr_reg     <= LOCK_THRESHOLD_RST;
            squelch_iter_reg <= SQUELCH_ITERATION_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_LOCK_THRESHOLD)
            begin
                lock_thr_reg <= cfg_data;
            end
            if (cfg_index == REG_SQUELCH_ITERATION)
            begin
                squelch_iter_reg <= cfg_data;
            end
        end
    end

    // Window: a chain of cells, newest address entering at cell zero
    assign chain[0] = pc;

    for (genvar g = 0; g < WINDOW_DEPTH; g++)
    begin : g_cell
        tld_cell u_cell
        (
            .clk      (clk),
            .shift_en (shift_en),
            .d_in     (chain[g]),
            .pc       (pc),
            .d_out    (chain[g+1]),
            .hit      (hits[g])
        );
    end

    assign hit_any  = |hits;
    assign full     = (fill_reg == FILL_FULL);
    assign need     = (lock_thr_reg == '0) ? cfg_t'(1) : lock_thr_reg;
    assign run_inc  = (hit_run_reg == '1) ? hit_run_reg : hit_run_reg + cfg_t'(1);
    assign iter_inc = (iter_reg == COUNT_MAX) ? iter_reg : iter_reg + count_t'(1);

    // Shift while searching, and on the exit step to hold the leaving address
    assign shift_en = in_acc && (!locked_reg || !hit_any);

    // Next loop state for the beat on the input
    always_comb
    begin
        fill_next      = fill_reg;
        locked_next    = locked_reg;
        squelch_next   = squelch_reg;
        hit_run_next   = hit_run_reg;
        head_next      = head_reg;
        iter_next      = iter_reg;
        event_next     = EV_NONE;
        iters_out_next = iter_reg;

        if (!locked_reg)
        begin
            if (full)
            begin
                if (hit_any)
                begin
                    if (hit_run_reg == '0)
                    begin
                        head_next = pc;
                    end
                    hit_run_next = run_inc;
                    if (run_inc >= need)
                    begin
                        locked_next = 1'b1;
                        iter_next   = count_t'(1);
                        event_next  = EV_LOCK;
                    end
                end
                else
                begin
                    hit_run_next = '0;
                end
            end
            else
            begin
                fill_next = fill_reg + FILL_ONE;
            end
            iters_out_next = iter_next;
        end
        else if (!hit_any)
        begin
            // Drop the loop and restart with only this address in the window
            event_next     = squelch_reg ? EV_EXIT_SQ : EV_EXIT_QUIET;
            iters_out_next = iter_reg;
            locked_next    = 1'b0;
            squelch_next   = 1'b0;
            hit_run_next   = '0;
            iter_next      = '0;
            fill_next      = FILL_ONE;
        end
        else
        begin
            if (pc == head_reg)
            begin
                iter_next = iter_inc;
                if (iter_inc == count_t'(squelch_iter_reg))
                begin
                    squelch_next = 1'b1;
                    event_next   = EV_SQUELCH;
                end
            end
            iters_out_next = iter_next;
        end
    end

    // Update loop state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            locked_reg  <= 1'b0;
            squelch_reg <= 1'b0;
            hit_run_reg <= '0;
            head_reg    <= '0;
            iter_reg    <= '0;
        end
        else if (in_acc)
        begin
            fill_reg    <= fill_next;
            locked_reg  <= locked_next;
            squelch_reg <= squelch_next;
            hit_run_reg <= hit_run_next;
            head_reg    <= head_next;
            iter_reg    <= iter_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            event_reg       <= event_next;
            iters_out_reg   <= iters_out_next;
            suppressing_reg <= squelch_next;
            locked_out_reg  <= locked_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = event_reg;
    assign iterations  = iters_out_reg;
    assign suppressing = suppressing_reg;
    assign locked      = locked_out_reg;

    // A locked loop always has a full window
    a_locked_full: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> full)
        else $error("loop locked with window not full");

    // Suppression only exists inside a locked loop
    a_squelch_locked: assert property (@(posedge clk) disable iff (!rst_n)
        squelch_reg |-> locked_reg)
        else $error("suppression active without a locked loop");

    // Iteration count is zero whenever no loop is locked
    a_iter_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !locked_reg |-> (iter_reg == '0))
        else $error("iteration count held while searching");

    // A lock event leaves the loop locked with one iteration
    a_lock_event: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && event_next == EV_LOCK) |=> (locked_reg && iter_reg == count_t'(1)))
        else $error("lock event without lock state");

endmodule

// File: sv/tld_cell.sv
// One window cell: holds an address, passes it on, compares it with the incoming pc.
module tld_cell
(
    input  logic          clk,
    input  logic          shift_en,
    input  tld_pkg::addr_t d_in,
    input  tld_pkg::addr_t pc,
    output tld_pkg::addr_t d_out,
    output logic          hit
);
    import tld_pkg::*;

    addr_t entry_reg;

    // Advance the window by one place
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= d_in;
        end
    end

    assign d_out = entry_reg;
    assign hit   = (entry_reg == pc);

endmodule

// File: verif/trace_loop_detector_test.sv
// Self-checking testbench for the trace loop detector: directed warm-up, then randomised loop traces.
module trace_loop_detector_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tld_pkg::*;

    localparam int TRAIL_DEPTH = 16;

    // One result beat as the detector should report it
    typedef struct packed {
        event_t code;
        count_t count;
        logic   quiet;
        logic   held;
    } loop_report_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    cfg_t   cfg_index = '0;
    cfg_t   cfg_data = '0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    addr_t  pc = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    event_t event_res;
    count_t iterations;
    logic   suppressing;
    logic   locked;

    // Stimulus and scoreboard
    addr_t        pending_pcs[$];
    loop_report_t awaited_reports[$];
    int unsigned  pcs_queued = 0;
    int unsigned  pc_beats = 0;
    int unsigned  cfg_beats = 0;
    int           fail_count = 0;
    logic         pc_fire = 1'b0;
    logic         backlog_hold = 1'b0;
    int           pc_gap = 0;
    int           pc_calm = 0;
    int           ready_gap = 0;
    int           ready_calm = 0;

    // Shadow of the detector state
    cfg_t        lock_need = LOCK_THRESHOLD_RST;
    cfg_t        mute_at = SQUELCH_ITERATION_RST;
    addr_t       trail[TRAIL_DEPTH];
    int unsigned trail_fill = 0;
    int unsigned trail_wr = 0;
    bit          tracking = 1'b0;
    bit          muted = 1'b0;
    int unsigned run_len = 0;
    addr_t       head_pc = '0;
    count_t      laps = '0;

    trace_loop_detector #(.WINDOW_DEPTH(TRAIL_DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pc          (pc),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .iterations  (iterations),
        .suppressing (suppressing),
        .locked      (locked)
    );

    always #2 clk = ~clk;

    // Only the filled part of the trail takes part in the search
    function automatic bit seen_in_trail(addr_t a);
        for (int i = 0; i < trail_fill && i < TRAIL_DEPTH; i++)
        begin
            if (trail[i] == a)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void append_trail(addr_t a);
        trail[trail_wr] = a;
        trail_wr = (trail_wr + 1) % TRAIL_DEPTH;
        if (trail_fill < TRAIL_DEPTH)
            trail_fill++;
    endfunction

    // Advance the shadow state by one pc and return the report it produces
    function automatic loop_report_t step_loop_tracker(addr_t a);
        loop_report_t rep;
        int unsigned  need;
        need = (lock_need == 0) ? 1 : lock_need;
        rep.code = EV_NONE;
        if (!tracking)
        begin
            if (trail_fill >= TRAIL_DEPTH)
            begin
                if (seen_in_trail(a))
                begin
                    if (run_len == 0)
                        head_pc = a;
                    if (run_len < 255)
                        run_len++;
                    if (run_len >= need)
                    begin
                        tracking = 1'b1;
                        laps = 1;
                        rep.code = EV_LOCK;
                    end
                end
                else
                    run_len = 0;
            end
            // the locking pc still lands in the trail before it freezes
            append_trail(a);
            rep.count = laps;
        end
        else if (!seen_in_trail(a))
        begin
            rep.code = muted ? EV_EXIT_SQ : EV_EXIT_QUIET;
            rep.count = laps;
            tracking = 1'b0;
            muted = 1'b0;
            run_len = 0;
            laps = '0;
            trail_fill = 0;
            trail_wr = 0;
            append_trail(a);
        end
        else
        begin
            if (a == head_pc)
            begin
                if (laps != COUNT_MAX)
                    laps++;
                if (laps == count_t'(mute_at))
                begin
                    muted = 1'b1;
                    rep.code = EV_SQUELCH;
                end
            end
            rep.count = laps;
        end
        rep.quiet = muted;
        rep.held = tracking;
        return rep;
    endfunction

    function automatic void compare_field(string label, longint unsigned want,
                                          longint unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 90)
            return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    function automatic addr_t random_pc();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void push_pc(addr_t a);
        pending_pcs = {pending_pcs, a};
        pcs_queued++;
    endfunction

    // Watch every beat: predict on pc beats, track register writes, check results
    always @(posedge clk)
    begin : watch_beats
        loop_report_t want;
        if (rst_n)
        begin
            pc_fire <= in_valid && in_ready;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOCK_THRESHOLD)
                    lock_need = cfg_data;
                else if (cfg_index == REG_SQUELCH_ITERATION)
                    mute_at = cfg_data;
                cfg_beats <= cfg_beats + 1;
            end
            if (in_valid && in_ready)
            begin
                awaited_reports = {awaited_reports, step_loop_tracker(pc)};
                pc_beats <= pc_beats + 1;
            end
            if (out_valid && out_ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $display("%0t ns: result beat with none expected: event %0d, iterations %0d",
                             $time, event_res, iterations);
                    fail_count++;
                end
                else
                begin
                    want = awaited_reports[0];
                    awaited_reports.delete(0);
                    compare_field("event_res", want.code, event_res);
                    compare_field("iterations", want.count, iterations);
                    compare_field("suppressing", want.quiet, suppressing);
                    compare_field("locked", want.held, locked);
                end
            end
        end
    end

    // Offer pending pcs, holding each beat until it is taken
    always @(negedge clk)
    begin : drive_pcs
        if (!in_valid || pc_fire)
        begin
            if (pc_gap > 0)
            begin
                in_valid <= 1'b0;
                pc_gap <= pc_gap - 1;
            end
            else if (pending_pcs.size() != 0)
            begin
                in_valid <= 1'b1;
                pc <= pending_pcs[0];
                pending_pcs.delete(0);
                if (pc_calm > 0)
                begin
                    pc_calm <= pc_calm - 1;
                    pc_gap <= 0;
                end
                else
                begin
                    pc_gap <= ($urandom_range(0, 1) == 0) ? 0 : draw_gap();
                    if ($urandom_range(0, 24) == 0)
                        pc_calm <= $urandom_range(20, 80);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Pace the result side with random stalls
    always @(negedge clk)
    begin : pace_results
        if (backlog_hold)
            out_ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (ready_calm > 0)
                ready_calm <= ready_calm - 1;
            else if ($urandom_range(0, 3) == 0)
            begin
                ready_gap <= draw_gap();
                if ($urandom_range(0, 19) == 0)
                    ready_calm <= $urandom_range(20, 60);
            end
        end
    end

    // Hold the result side off for a long stretch while pcs keep coming
    initial
    begin : backlog_stall
        while (pc_beats < 250 || pending_pcs.size() < 40)
            @(negedge clk);
        @(posedge clk);
        backlog_hold <= 1'b1;
        repeat (200) @(posedge clk);
        backlog_hold <= 1'b0;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("** trace_loop_detector: FAILED **");
        $finish;
    end

    // Wait until no pc is queued, offered or awaiting its result
    task automatic wait_drained();
        while (pending_pcs.size() != 0 || in_valid || awaited_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Leaves valid high; the caller drops it after the last write
    task automatic write_register(input cfg_t idx, input cfg_t val);
        int unsigned seen;
        seen = cfg_beats;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(negedge clk);
        while (cfg_beats == seen)
            @(negedge clk);
    endtask

    // Reset thresholds: fill with corner addresses, lock on all ones, squelch, exit
    task automatic queue_warmup();
        addr_t warmup[16];
        warmup = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAA, 64'h1, 64'h8000_0000_0000_0000,
                   64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                   64'hFFFF_FFFF_0000_0000, 64'h0F0F_0F0F_0F0F_0F0F,
                   64'hF0F0_F0F0_F0F0_F0F0, 64'h00FF_00FF_00FF_00FF,
                   64'hFF00_FF00_FF00_FF00, 64'h3333_3333_3333_3333,
                   64'hCCCC_CCCC_CCCC_CCCC, 64'hDEAD_BEEF_0BAD_F00D};
        foreach (warmup[i])
            push_pc(warmup[i]);
        repeat (8) push_pc(64'hFFFF_FFFF_FFFF_FFFF);
        push_pc(64'h0123_4567_89AB_CDEF);
    endtask

    // One trace: either noise or a loop body repeated long enough to lock, and often to squelch
    task automatic queue_trace(input int need, input int mute);
        addr_t body[TRAIL_DEPTH];
        int    body_len;
        int    lap_goal;
        int    steps;
        int    stray_at;
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(3, 30))
                push_pc(($urandom_range(0, 1) == 0) ? random_pc()
                                                    : addr_t'(64'h4000 + 8 * $urandom_range(0, 7)));
            return;
        end
        if (need + mute > 24)
            body_len = $urandom_range(1, 2);
        else if ($urandom_range(0, 1) == 0)
            body_len = $urandom_range(1, 4);
        else
            body_len = $urandom_range(1, TRAIL_DEPTH);
        for (int i = 0; i < body_len; i++)
            body[i] = (i > 0 && $urandom_range(0, 7) == 0) ? body[$urandom_range(0, i - 1)]
                                                           : random_pc();
        if (mute <= 1)
            lap_goal = $urandom_range(1, 4);
        else if ($urandom_range(0, 3) != 0)
            lap_goal = mute + $urandom_range(0, 2);
        else
            lap_goal = $urandom_range(1, mute);
        steps = TRAIL_DEPTH + body_len + need + (lap_goal - 1) * body_len
                + $urandom_range(0, body_len - 1);
        // now and then break the run with a stray address
        stray_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, steps - 1) : -1;
        for (int i = 0; i < steps; i++)
        begin
            if (i == stray_at)
                push_pc(random_pc());
            push_pc(body[i % body_len]);
        end
        push_pc(random_pc());
    endtask

    task automatic run_phase(input cfg_t lock_cfg, input cfg_t mute_cfg, input int budget);
        int unsigned mark;
        wait_drained();
        write_register(REG_LOCK_THRESHOLD, lock_cfg);
        write_register(REG_SQUELCH_ITERATION, mute_cfg);
        cfg_valid <= 1'b0;
        mark = pcs_queued;
        while (pcs_queued - mark < budget)
            queue_trace((lock_cfg == 0) ? 1 : int'(lock_cfg), int'(mute_cfg));
    endtask

    initial
    begin : run_test
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_warmup();
        run_phase(8'd1, 8'd1, 30);
        run_phase(8'd0, 8'd0, 20);
        run_phase(8'd255, 8'd3, 200);
        run_phase(8'd2, 8'd255, 200);
        run_phase(cfg_t'($urandom_range(1, 12)), cfg_t'($urandom_range(2, 10)), 30);
        run_phase(cfg_t'($urandom_range(1, 12)), cfg_t'($urandom_range(2, 10)), 20);
        wait_drained();
        if (fail_count == 0 && awaited_reports.size() == 0)
            $display("** trace_loop_detector: PASSED **");
        else
            $display("** trace_loop_detector: FAILED **");
        $finish;
    end

endmodule
